// ===== hw/rtl/hmn_pkg.sv =====
// ----------------------------------------------------------------------------
// hmn_pkg
// Shared constants, codes and command types of the height-map normal stream.
// ----------------------------------------------------------------------------
package hmn_pkg;

   localparam int MAX_WIDTH_DEF = 256;
   localparam int MAX_ROWS_DEF  = 4096;

   localparam int HEIGHT_W = 16;
   localparam int NORM_W   = 16;
   localparam int GW_W     = 9;
   localparam int GH_W     = 13;

   // squared length fits 52 bits, root 26 bits, quotient at most 2^14
   localparam int SUM_W      = 52;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int ROOT_STEPS = SUM_W / 4;
   localparam int QUOT_W     = 15;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int NUM_W      = 39;
   localparam int STEP_W     = 4;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_U,
      CAP_C,
      CAP_L,
      CAP_R
   } cap_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PREP,
      OP_SQR,
      OP_SUM,
      OP_ROOT,
      OP_DINIT,
      OP_DIV,
      OP_LOAD
   } op_type;

   typedef struct packed {
      logic    take;
      logic    rd_en;
      logic    wr_en;
      cap_type cap;
      op_type  op;
   } dp_cmd_type;

   typedef struct packed {
      logic left;
      logic right;
      logic top;
      logic flush;
      logic last;
      logic emit;
   } job_flags_type;

endpackage

// ===== hw/rtl/hmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmn_ctrl
// Sequencer: grid position counters, flush tracking and per-beat command
// sequence for row store access, square root and divide.
// ----------------------------------------------------------------------------
module hmn_ctrl import hmn_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_ROWS),
   localparam int AW = $clog2(2 * MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_stall,
   input  logic [CW-1:0]       width_last,
   input  logic [RW-1:0]       height_last,
   input  logic                out_free,
   output dp_cmd_type          cmd,
   output logic [AW-1:0]       mem_addr,
   output logic [CW-1:0]       job_x,
   output logic [RW-1:0]       job_r,
   output job_flags_type       job_flags
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_U,
      ST_RD_C,
      ST_RD_L,
      ST_RD_R,
      ST_WR,
      ST_PREP,
      ST_SQR,
      ST_SUM,
      ST_ROOT,
      ST_DINIT,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] fcol_ff, fcol_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0] job_x_ff, job_x_in;
   logic [RW-1:0] job_r_ff, job_r_in;
   job_flags_type job_ff, job_in;

   function automatic logic [AW-1:0] slot_addr(input logic par, input logic [CW-1:0] col);
      slot_addr = par ? AW'(MAX_WIDTH) + AW'(col) : AW'(col);
   endfunction

   logic [AW-1:0] addr_u, addr_c, addr_l, addr_r;

   always_comb begin
      addr_u = slot_addr(~job_r_ff[0], job_x_ff);
      addr_c = slot_addr(job_r_ff[0], job_x_ff);
      addr_l = slot_addr(job_r_ff[0], CW'(job_x_ff - 1'b1));
      addr_r = slot_addr(job_r_ff[0], CW'(job_x_ff + 1'b1));
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      fcol_in  = fcol_ff;
      step_in  = step_ff;
      job_x_in = job_x_ff;
      job_r_in = job_r_ff;
      job_in   = job_ff;
      cmd      = '{take: 1'b0, rd_en: 1'b0, wr_en: 1'b0, cap: CAP_NONE, op: OP_NONE};
      mem_addr = addr_u;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  // samples are dropped while the last row drains
                  if (!pend_ff) begin
                     cmd.take    = 1'b1;
                     job_x_in    = col_ff;
                     job_r_in    = RW'(row_ff - 1'b1);
                     job_in      = '{left: col_ff == '0, right: col_ff >= width_last,
                                     top: row_ff == RW'(1), flush: 1'b0, last: 1'b0,
                                     emit: row_ff != '0};
                     state_in    = ST_RD_U;
                     if (col_ff >= width_last) begin
                        col_in = '0;
                        if (row_ff >= height_last) begin
                           pend_in = 1'b1;
                           fcol_in = '0;
                        end else begin
                           row_in = RW'(row_ff + 1'b1);
                        end
                     end else begin
                        col_in = CW'(col_ff + 1'b1);
                     end
                  end
               end else if (pend_ff) begin
                  job_x_in = fcol_ff;
                  job_r_in = row_ff;
                  job_in   = '{left: fcol_ff == '0, right: fcol_ff >= width_last,
                               top: row_ff == '0, flush: 1'b1,
                               last: fcol_ff >= width_last, emit: 1'b1};
                  state_in = ST_RD_U;
                  if (fcol_ff >= width_last) begin
                     pend_in = 1'b0;
                     fcol_in = '0;
                     row_in  = '0;
                     col_in  = '0;
                  end else begin
                     fcol_in = CW'(fcol_ff + 1'b1);
                  end
               end
            end
         end
         ST_RD_U: begin
            cmd.rd_en = 1'b1;
            mem_addr  = addr_u;
            state_in  = ST_RD_C;
         end
         ST_RD_C: begin
            cmd.rd_en = 1'b1;
            cmd.cap   = CAP_U;
            mem_addr  = addr_c;
            state_in  = ST_RD_L;
         end
         ST_RD_L: begin
            cmd.rd_en = 1'b1;
            cmd.cap   = CAP_C;
            mem_addr  = addr_l;
            state_in  = ST_RD_R;
         end
         ST_RD_R: begin
            cmd.rd_en = 1'b1;
            cmd.cap   = CAP_L;
            mem_addr  = addr_r;
            state_in  = ST_WR;
         end
         ST_WR: begin
            // new sample replaces the row two back, after its read
            cmd.cap   = CAP_R;
            cmd.wr_en = !job_ff.flush;
            mem_addr  = addr_u;
            state_in  = job_ff.emit ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.op   = OP_PREP;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            cmd.op   = OP_SQR;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op  = OP_ROOT;
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.op   = OP_DINIT;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = OP_DIV;
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.op   = OP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= 1'b0;
         fcol_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         fcol_ff  <= fcol_in;
         step_ff  <= step_in;
         job_x_ff <= job_x_in;
         job_r_ff <= job_r_in;
         job_ff   <= job_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign job_x     = job_x_ff;
   assign job_r     = job_r_ff;
   assign job_flags = job_ff;

endmodule

// ===== hw/rtl/hmn_dp.sv =====
// ----------------------------------------------------------------------------
// hmn_dp
// Datapath: row store, neighbor registers, squares, digit-serial square root,
// three restoring dividers and the result register.
// ----------------------------------------------------------------------------
module hmn_dp import hmn_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_ROWS),
   localparam int AW = $clog2(2 * MAX_WIDTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [HEIGHT_W-1:0]      req_height,
   input  dp_cmd_type               cmd,
   input  logic [AW-1:0]            mem_addr,
   input  logic [CW-1:0]            job_x,
   input  logic [RW-1:0]            job_r,
   input  job_flags_type            job_flags,
   output logic                     out_free,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [NORM_W-1:0] rsp_normal_x,
   output logic signed [NORM_W-1:0] rsp_normal_y,
   output logic signed [NORM_W-1:0] rsp_normal_z,
   output logic [CW-1:0]            rsp_column,
   output logic [RW-1:0]            rsp_row,
   output logic                     rsp_last_of_frame
);

   localparam int DEPTH = 2 * MAX_WIDTH;
   localparam int REM_W = ROOT_W + 2;

   logic [HEIGHT_W-1:0] store_mem [DEPTH];
   logic [HEIGHT_W-1:0] rdata_ff;
   logic [HEIGHT_W-1:0] hin_ff, hu_ff, hc_ff, hl_ff, hr_ff;
   logic [HEIGHT_W-1:0] ay_mag_ff, by_mag_ff;
   logic                nx_neg_ff, nz_neg_ff, xedge_ff, yedge_ff;
   logic [31:0]         ay2_ff, by2_ff;
   logic [SUM_W-1:0]    val_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [NUM_W-1:0]    nrem_ff [3];
   logic [NUM_W:0]      dsh_ff;
   logic [QUOT_W-1:0]   quot_ff [3];
   logic                rsp_valid_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic [CW-1:0]       col_ff;
   logic [RW-1:0]       row_ff;
   logic                last_ff;

   // row store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[mem_addr] <= hin_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

   // edge substitution: a missing neighbor is the center sample
   logic [HEIGHT_W-1:0] hl_e, hr_e, hu_e, hd_e;
   logic [1:0]          shrink;

   always_comb begin
      hl_e   = job_flags.left  ? hc_ff : hl_ff;
      hr_e   = job_flags.right ? hc_ff : hr_ff;
      hu_e   = job_flags.top   ? hc_ff : hu_ff;
      hd_e   = job_flags.flush ? hc_ff : hin_ff;
      shrink = 2'(!xedge_ff) + 2'(!yedge_ff);
   end

   logic [SUM_W-1:0] ny2;

   always_comb begin
      case (shrink)
         2'd0:    ny2 = SUM_W'(1) << 32;
         2'd1:    ny2 = SUM_W'(1) << 34;
         default: ny2 = SUM_W'(1) << 36;
      endcase
   end

   // two root digits per cycle
   logic [REM_W-1:0]  rem_nx;
   logic [ROOT_W-1:0] root_nx;
   logic [REM_W+1:0]  rtmp, trial;

   always_comb begin
      rem_nx  = rem_ff;
      root_nx = root_ff;
      for (int i = 0; i < 2; i++) begin
         rtmp  = {rem_nx, val_ff[SUM_W-1-2*i -: 2]};
         trial = (REM_W+2)'({root_nx, 2'b01});
         if (rtmp >= trial) begin
            rem_nx  = REM_W'(rtmp - trial);
            root_nx = {root_nx[ROOT_W-2:0], 1'b1};
         end else begin
            rem_nx  = REM_W'(rtmp);
            root_nx = {root_nx[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         hin_ff <= req_height;
      end
      case (cmd.cap)
         CAP_U:   hu_ff <= rdata_ff;
         CAP_C:   hc_ff <= rdata_ff;
         CAP_L:   hl_ff <= rdata_ff;
         CAP_R:   hr_ff <= rdata_ff;
         default: ;
      endcase
      case (cmd.op)
         OP_PREP: begin
            nx_neg_ff <= hl_e > hr_e;
            ay_mag_ff <= (hl_e > hr_e) ? HEIGHT_W'(hl_e - hr_e) : HEIGHT_W'(hr_e - hl_e);
            nz_neg_ff <= hu_e > hd_e;
            by_mag_ff <= (hu_e > hd_e) ? HEIGHT_W'(hu_e - hd_e) : HEIGHT_W'(hd_e - hu_e);
            xedge_ff  <= job_flags.left | job_flags.right;
            yedge_ff  <= job_flags.top | job_flags.flush;
         end
         OP_SQR: begin
            ay2_ff <= ay_mag_ff * ay_mag_ff;
            by2_ff <= by_mag_ff * by_mag_ff;
         end
         OP_SUM: begin
            val_ff  <= (SUM_W'(ay2_ff) << (yedge_ff ? 16 : 18))
                     + (SUM_W'(by2_ff) << (xedge_ff ? 16 : 18)) + ny2;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_ROOT: begin
            rem_ff  <= rem_nx;
            root_ff <= root_nx;
            val_ff  <= val_ff << 4;
         end
         OP_DINIT: begin
            // part magnitudes already scaled by 2^14
            nrem_ff[0] <= NUM_W'(ay_mag_ff) << (yedge_ff ? 22 : 23);
            nrem_ff[1] <= NUM_W'(1) << (30 + 32'(shrink));
            nrem_ff[2] <= NUM_W'(by_mag_ff) << (xedge_ff ? 22 : 23);
            dsh_ff     <= (NUM_W+1)'(root_ff) << 14;
            for (int j = 0; j < 3; j++) begin
               quot_ff[j] <= '0;
            end
         end
         OP_DIV: begin
            for (int j = 0; j < 3; j++) begin
               if ({1'b0, nrem_ff[j]} >= dsh_ff) begin
                  nrem_ff[j] <= NUM_W'({1'b0, nrem_ff[j]} - dsh_ff);
                  quot_ff[j] <= {quot_ff[j][QUOT_W-2:0], 1'b1};
               end else begin
                  quot_ff[j] <= {quot_ff[j][QUOT_W-2:0], 1'b0};
               end
            end
            dsh_ff <= dsh_ff >> 1;
         end
         OP_LOAD: begin
            nx_ff   <= nx_neg_ff ? NORM_W'(-{1'b0, quot_ff[0]}) : NORM_W'(quot_ff[0]);
            ny_ff   <= NORM_W'(-{1'b0, quot_ff[1]});
            nz_ff   <= nz_neg_ff ? NORM_W'(-{1'b0, quot_ff[2]}) : NORM_W'(quot_ff[2]);
            col_ff  <= job_x;
            row_ff  <= job_r;
            last_ff <= job_flags.last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_normal_x      = nx_ff;
   assign rsp_normal_y      = ny_ff;
   assign rsp_normal_z      = nz_ff;
   assign rsp_column        = col_ff;
   assign rsp_row           = row_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

// ===== hw/rtl/heightmap_normal_stream.sv =====
// A taken beat reads the up, center, left and right samples (a sample beat then writes
// its height), prepares the differences, squares, sums, runs the square root (two
// digits a cycle) and the restoring divide (three lanes side by side), then loads the
// result register once the previous result is taken; no beat is taken meanwhile.
// A first-row sample stops after the row store access; a dropped sample or a flush
// with nothing pending leaves the sequencer idle. Reset (synchronous) clears counters
// and flush state, sets both sizes to 256; the row store is not cleared.
// ----------------------------------------------------------------------------
// heightmap_normal_stream
// Streams height samples in row-major order and returns unit surface normals
// from central differences, one row behind the input.
// ----------------------------------------------------------------------------
module heightmap_normal_stream import hmn_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_ROWS),
   localparam int AW = $clog2(2 * MAX_WIDTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [HEIGHT_W-1:0]      req_height,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [NORM_W-1:0] rsp_normal_x,
   output logic signed [NORM_W-1:0] rsp_normal_y,
   output logic signed [NORM_W-1:0] rsp_normal_z,
   output logic [CW-1:0]            rsp_column,
   output logic [RW-1:0]            rsp_row,
   output logic                     rsp_last_of_frame,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [GW_W-1:0] grid_width_ff;
   logic [GH_W-1:0] grid_height_ff;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GW_W'(256);
         grid_height_ff <= GH_W'(256);
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_GRID_WIDTH) begin
            grid_width_ff <= csr_pwdata[GW_W-1:0];
         end else begin
            grid_height_ff <= csr_pwdata[GH_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_GRID_HEIGHT) ? 32'(grid_height_ff)
                                                          : 32'(grid_width_ff);

   // last column and last row after clamping
   logic [CW-1:0] width_last;
   logic [RW-1:0] height_last;

   always_comb begin
      if (grid_width_ff < GW_W'(2)) begin
         width_last = CW'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         width_last = CW'(MAX_WIDTH - 1);
      end else begin
         width_last = CW'(grid_width_ff - 1'b1);
      end
      if (grid_height_ff < GH_W'(2)) begin
         height_last = RW'(1);
      end else if (32'(grid_height_ff) > MAX_ROWS) begin
         height_last = RW'(MAX_ROWS - 1);
      end else begin
         height_last = RW'(grid_height_ff - 1'b1);
      end
   end

   dp_cmd_type    cmd;
   logic [AW-1:0] mem_addr;
   logic [CW-1:0] job_x;
   logic [RW-1:0] job_r;
   job_flags_type job_flags;
   logic          out_free;

   hmn_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .width_last (width_last),
      .height_last(height_last),
      .out_free   (out_free),
      .cmd        (cmd),
      .mem_addr   (mem_addr),
      .job_x      (job_x),
      .job_r      (job_r),
      .job_flags  (job_flags)
   );

   hmn_dp #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_height       (req_height),
      .cmd              (cmd),
      .mem_addr         (mem_addr),
      .job_x            (job_x),
      .job_r            (job_r),
      .job_flags        (job_flags),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_last_of_frame(rsp_last_of_frame)
   );

   // height-axis part is always negative and never below -1.0
   a_ny_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_y < 0) && (rsp_normal_y >= -16'sd16384))
      else $error("normal_y out of range");

   a_nxz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x >= -16'sd16384) && (rsp_normal_x <= 16'sd16384)
                 && (rsp_normal_z >= -16'sd16384) && (rsp_normal_z <= 16'sd16384))
      else $error("normal_x or normal_z out of range");

   // a stalled result beat holds still until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_column)
         && $stable(rsp_row) && $stable(rsp_last_of_frame))
      else $error("result changed while stalled");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heightmap_normal_stream: height beats go in, unit
// normals come out and are compared with an in-bench normal predictor.
// ----------------------------------------------------------------------------
module tb import hmn_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCH_LIMIT = 3000;
   localparam int SETTLE      = 60;
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_FLUSH  = 1'b1;

   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [7:0]         col;
      logic [11:0]        row;
      logic               last;
   } normal_type;

   typedef struct {
      logic       act;
      int         h;
      bit         typed;
      normal_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_action = 1'b0;
   logic [15:0] req_height = '0;
   logic req_stall, rsp_valid, rsp_last_of_frame;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [7:0] rsp_column;
   logic [11:0] rsp_row;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   always #6 clock = ~clock;

   heightmap_normal_stream u_top (.*);

   // predictor state
   logic [15:0] heights [512];
   int  col_q, row_q, flush_col;
   bit  flush_wait, frame_done;
   int  gw_reg, gh_reg;

   normal_type expected_normals [$];
   int errors, beats_sent, hold_cycles, quiet;
   int send_pct, stall_pct;

   function automatic int width_used();
      return gw_reg < 2 ? 2 : (gw_reg > 256 ? 256 : gw_reg);
   endfunction

   function automatic int height_used();
      return gh_reg < 2 ? 2 : (gh_reg > 4096 ? 4096 : gh_reg);
   endfunction

   function automatic int slot(int r, int c);
      return (r & 1) * 256 + c;
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] to_q14(longint p, longint unsigned len);
      longint unsigned mag, q;
      mag = (p < 0) ? -p : p;
      q = (mag * 16384) / len;
      if (q > 16384) q = 16384;
      return (p < 0) ? -q[15:0] : q[15:0];
   endfunction

   // normal of (x, r); row r lives in the store, hu/hd are the rows around it
   function automatic normal_type surface_normal(int x, int r, longint hu, longint hd,
                                                 bit last_row, bit last);
      normal_type n;
      longint hc, hl, hr, ax, bz, vx, vy, vz;
      longint unsigned len;
      bit right_edge;
      right_edge = (x >= width_used() - 1);
      hc = longint'(heights[slot(r, x)]);
      hl = (x == 0) ? hc : longint'(heights[slot(r, x - 1)]);
      hr = right_edge ? hc : longint'(heights[slot(r, x + 1)]);
      if (r == 0) hu = hc;
      if (last_row) hd = hc;
      ax = (x == 0 || right_edge) ? -256 : -512;
      bz = (r == 0 || last_row) ? -256 : -512;
      vx = (hl - hr) * bz;
      vy = -ax * bz;
      vz = ax * (hu - hd);
      len = int_root(vx * vx + vy * vy + vz * vz);
      if (len == 0) len = 1;
      n.nx = to_q14(vx, len);
      n.ny = to_q14(vy, len);
      n.nz = to_q14(vz, len);
      n.col = x[7:0];
      n.row = r[11:0];
      n.last = last;
      return n;
   endfunction

   // advance the predictor by one accepted beat
   task automatic predict_beat(logic act, logic [15:0] h);
      int w, hh, x, y;
      longint up;
      bit done;
      w = width_used();
      hh = height_used();
      if (act == ACT_FLUSH) begin
         if (flush_wait) begin
            x = flush_col;
            done = (x >= w - 1);
            expected_normals.push_back(surface_normal(x, row_q,
               longint'(heights[slot(row_q - 1, x)]), 0, 1'b1, done));
            if (done) begin
               flush_wait = 0;
               flush_col = 0;
               row_q = 0;
               col_q = 0;
               frame_done = 1;
            end else begin
               flush_col = x + 1;
            end
         end
      end else if (!flush_wait) begin
         x = col_q;
         y = row_q;
         up = longint'(heights[slot(y, x)]);
         heights[slot(y, x)] = h;
         if (y >= 1)
            expected_normals.push_back(surface_normal(x, y - 1, up, longint'(h),
                                                      1'b0, 1'b0));
         if (x >= w - 1) begin
            col_q = 0;
            if (y >= hh - 1) begin
               flush_wait = 1;
               flush_col = 0;
            end else begin
               row_q = y + 1;
            end
         end else begin
            col_q = x + 1;
         end
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      normal_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            report_mismatch("unexpected beat col", int'(rsp_column), -1);
         end else begin
            e = expected_normals.pop_front();
            if (rsp_normal_x !== e.nx)
               report_mismatch("normal_x", int'(rsp_normal_x), int'(e.nx));
            if (rsp_normal_y !== e.ny)
               report_mismatch("normal_y", int'(rsp_normal_y), int'(e.ny));
            if (rsp_normal_z !== e.nz)
               report_mismatch("normal_z", int'(rsp_normal_z), int'(e.nz));
            if (rsp_column !== e.col)
               report_mismatch("column", int'(rsp_column), int'(e.col));
            if (rsp_row !== e.row) report_mismatch("row", int'(rsp_row), int'(e.row));
            if (rsp_last_of_frame !== e.last)
               report_mismatch("last_of_frame", int'(rsp_last_of_frame), int'(e.last));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted here
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on beats moving in either direction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= WATCH_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic set_idle_mode();
      if (beats_sent < 400) begin
         send_pct = 20;
         stall_pct = 62;
      end else if (beats_sent < 800) begin
         send_pct = 62;
         stall_pct = 20;
      end else begin
         send_pct = 0;
         stall_pct = 0;
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_beat(logic act, logic [15:0] h);
      set_idle_mode();
      if ($urandom_range(99) < send_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = act;
      req_height = h;
      do @(posedge clock); while (req_stall);
      predict_beat(act, h);
      beats_sent++;
      if (beats_sent == 300) hold_cycles = 500;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_normals.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic reg_sel, int value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {reg_sel, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (reg_sel == REG_GRID_WIDTH) gw_reg = value & 32'h1FF;
      else gh_reg = value & 32'h1FFF;
   endtask

   function automatic logic [15:0] pick_height(logic [15:0] prev);
      case ($urandom_range(3))
         0: return 16'($urandom_range(16'hFFFF));
         1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return 16'(prev + $urandom_range(2048) - 1024);
      endcase
   endfunction

   // stream one frame; stops early after max_beats samples if max_beats >= 0
   task automatic feed_frame(int max_beats);
      logic [15:0] h;
      int n;
      h = 16'($urandom);
      n = 0;
      frame_done = 0;
      while (!frame_done && (max_beats < 0 || n < max_beats)) begin
         if (flush_wait) begin
            if ($urandom_range(9) == 0) send_beat(ACT_SAMPLE, 16'($urandom));
            else send_beat(ACT_FLUSH, 16'($urandom));
         end else if ($urandom_range(19) == 0) begin
            send_beat(ACT_FLUSH, 16'($urandom));
         end else begin
            h = pick_height(h);
            send_beat(ACT_SAMPLE, h);
            n++;
         end
      end
   endtask

   stim_row_type directed [$];

   task automatic add_row(logic act, int h, bit typed, int c, int r, bit last);
      stim_row_type s;
      s.act = act;
      s.h = h;
      s.typed = typed;
      s.want = '{16'sd0, -16'sd16384, 16'sd0, c[7:0], r[11:0], last};
      directed.push_back(s);
   endtask

   initial begin
      int qn;
      errors = 0;
      beats_sent = 0;
      hold_cycles = 0;
      quiet = 0;
      send_pct = 20;
      stall_pct = 62;
      foreach (heights[i]) heights[i] = '0;
      col_q = 0; row_q = 0; flush_col = 0; flush_wait = 0;
      gw_reg = 256; gh_reg = 256;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // flat 3x2 frame: every normal points straight down the height axis
      for (int i = 0; i < 3; i++) add_row(ACT_SAMPLE, 16'h0100, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) add_row(ACT_SAMPLE, 16'h0100, 1, i, 0, 0);
      add_row(ACT_SAMPLE, 16'h1234, 0, 0, 0, 0);   // dropped, flush pending
      for (int i = 0; i < 3; i++) add_row(ACT_FLUSH, 0, 1, i, 1, i == 2);
      add_row(ACT_FLUSH, 0, 0, 0, 0, 0);           // nothing pending
      // extreme heights
      add_row(ACT_SAMPLE, 16'h0000, 0, 0, 0, 0);
      add_row(ACT_SAMPLE, 16'hFFFF, 0, 0, 0, 0);
      add_row(ACT_SAMPLE, 16'h0000, 0, 0, 0, 0);
      add_row(ACT_SAMPLE, 16'hFFFF, 0, 0, 0, 0);
      add_row(ACT_SAMPLE, 16'h0000, 0, 0, 0, 0);
      add_row(ACT_SAMPLE, 16'hFFFF, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) add_row(ACT_FLUSH, 0, 0, 0, 0, 0);

      csr_write(REG_GRID_WIDTH, 3);
      csr_write(REG_GRID_HEIGHT, 2);
      foreach (directed[i]) begin
         qn = expected_normals.size();
         send_beat(directed[i].act, 16'(directed[i].h));
         if (directed[i].typed && expected_normals.size() == qn + 1)
            expected_normals[$] = directed[i].want;
      end
      drain();

      // below-range sizes clamp to 2x2
      csr_write(REG_GRID_WIDTH, 0);
      csr_write(REG_GRID_HEIGHT, 1);
      feed_frame(-1);
      drain();

      // oversized sizes clamp to 256 x 4096; height cut mid-frame
      csr_write(REG_GRID_WIDTH, 511);
      csr_write(REG_GRID_HEIGHT, 8191);
      feed_frame(512);
      drain();
      csr_write(REG_GRID_HEIGHT, 3);
      feed_frame(-1);
      drain();

      while (beats_sent < 1150) begin
         csr_write(REG_GRID_WIDTH, $urandom_range(2, 14));
         csr_write(REG_GRID_HEIGHT, $urandom_range(2, 7));
         feed_frame(-1);
         drain();
      end

      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
